>>> src/mczr_pkg.sv
// ----------------------------------------------------------------------------
// MIDI channel router package
// Shared types and constants for the MIDI channel, zone and controller router.
// ----------------------------------------------------------------------------
package mczr_pkg;

    localparam int MAP_ENTRIES = 128;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
    } msg_t;

    localparam logic [1:0] CMD_ROUTE     = 2'd0;
    localparam logic [1:0] CMD_MAP_WRITE = 2'd1;
    localparam logic [1:0] CMD_START     = 2'd2;

    localparam logic [2:0] REG_IN_CHANNEL  = 3'd0;
    localparam logic [2:0] REG_OUT_CHANNEL = 3'd1;
    localparam logic [2:0] REG_ZONE_LOW    = 3'd2;
    localparam logic [2:0] REG_ZONE_HIGH   = 3'd3;
    localparam logic [2:0] REG_TRANSPOSE   = 3'd4;
    localparam logic [2:0] REG_BANK_MSB    = 3'd5;
    localparam logic [2:0] REG_BANK_LSB    = 3'd6;
    localparam logic [2:0] REG_PROGRAM     = 3'd7;

    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS = 4'hA;
    localparam logic [3:0] HI_CONTROL    = 4'hB;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    localparam logic [7:0] MAP_BLOCKED = 8'hFF;
    localparam logic [6:0] CC_BANK_MSB = 7'd0;
    localparam logic [6:0] CC_BANK_LSB = 7'd32;
    localparam logic [7:0] NO_BOUND    = 8'hFF;

endpackage

>>> src/midi_channel_zone_cc_router.sv
// ----------------------------------------------------------------------------
// MIDI channel, zone and controller router
// Filters, transposes, rechannelizes and remaps short MIDI messages, and emits
// bank and program messages for a start transaction.
// One input transaction may be accepted every cycle while the input stage is
// free; an item holds the input stage until each message it emits (up to
// three, for a start transaction) is loaded into the output register. The
// controller map is a synchronous memory read when the message is accepted,
// and the result is registered in the output register. Map entries never
// written read as identity through a bank of per-entry valid flags cleared
// by reset, so no clearing pass is needed.
module midi_channel_zone_cc_router (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] status_byte,
    input  logic [6:0] first_data,
    input  logic [6:0] second_data,
    input  logic [6:0] map_entry,
    input  logic [6:0] map_target,
    input  logic       map_block,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_status,
    output logic [6:0] out_first,
    output logic [6:0] out_second,
    output logic       last_of_run
);

    logic [4:0] in_channel_reg;
    logic [4:0] out_channel_reg;
    logic [7:0] zone_low_reg;
    logic [7:0] zone_high_reg;
    logic [7:0] transpose_reg;
    logic [7:0] bank_msb_reg;
    logic [7:0] bank_lsb_reg;
    logic [7:0] program_reg;

    logic [7:0]                       map_mem [mczr_pkg::MAP_ENTRIES];
    logic [mczr_pkg::MAP_ENTRIES-1:0] map_valid_reg;
    logic [7:0]                       rd_data_reg;
    logic                             rd_valid_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_status_reg;
    logic [6:0] s1_first_reg;
    logic [6:0] s1_second_reg;
    logic [2:0] sent_reg;
    logic [2:0] sent_next;

    mczr_pkg::msg_t out_msg_reg;
    logic           out_valid_reg;
    logic           out_last_reg;

    logic           in_accept;
    logic           map_wr;
    logic           out_load_ok;
    logic           s1_fire;
    logic           s1_free;
    logic [2:0]     en;
    logic [2:0]     pending;
    logic [2:0]     sel_bit;
    logic           sel_last;
    mczr_pkg::msg_t cand [3];
    mczr_pkg::msg_t sel_msg;

    logic [3:0]        hi;
    logic [3:0]        start_ch;
    logic              chan_ok;
    logic              zone_ok;
    logic signed [9:0] note_sum;
    logic [7:0]        mapped;
    logic              rechan;
    logic              route_pass;
    logic [7:0]        route_status;
    logic [6:0]        route_first;

    assign in_accept = in_valid && in_ready;
    assign map_wr    = in_accept && (cmd == mczr_pkg::CMD_MAP_WRITE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channel_reg  <= 5'h1F;
            out_channel_reg <= 5'h1F;
            zone_low_reg    <= 8'hFF;
            zone_high_reg   <= 8'hFF;
            transpose_reg   <= 8'h00;
            bank_msb_reg    <= 8'hFF;
            bank_lsb_reg    <= 8'hFF;
            program_reg     <= 8'hFF;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mczr_pkg::REG_IN_CHANNEL:  in_channel_reg  <= cfg_data[4:0];
                mczr_pkg::REG_OUT_CHANNEL: out_channel_reg <= cfg_data[4:0];
                mczr_pkg::REG_ZONE_LOW:    zone_low_reg    <= cfg_data;
                mczr_pkg::REG_ZONE_HIGH:   zone_high_reg   <= cfg_data;
                mczr_pkg::REG_TRANSPOSE:   transpose_reg   <= cfg_data;
                mczr_pkg::REG_BANK_MSB:    bank_msb_reg    <= cfg_data;
                mczr_pkg::REG_BANK_LSB:    bank_lsb_reg    <= cfg_data;
                mczr_pkg::REG_PROGRAM:     program_reg     <= cfg_data;
                default:                   program_reg     <= program_reg;
            endcase
        end
    end

    // Controller map memory. Writes land at acceptance, so a following
    // message read sees them without forwarding.
    always_ff @(posedge clk)
    begin
        if (map_wr)
        begin
            map_mem[map_entry[mczr_pkg::MAP_AW-1:0]] <= map_block ? mczr_pkg::MAP_BLOCKED
                                                                  : {1'b0, map_target};
        end
        if (in_accept && (cmd == mczr_pkg::CMD_ROUTE))
        begin
            rd_data_reg  <= map_mem[first_data[mczr_pkg::MAP_AW-1:0]];
            rd_valid_reg <= map_valid_reg[first_data[mczr_pkg::MAP_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
        end
        else if (map_wr)
        begin
            map_valid_reg[map_entry[mczr_pkg::MAP_AW-1:0]] <= 1'b1;
        end
    end

    // Routing of the message held in the input stage.
    always_comb
    begin
        hi          = s1_status_reg[7:4];
        rechan      = !out_channel_reg[4];
        chan_ok     = (hi == mczr_pkg::HI_SYSTEM) || in_channel_reg[4]
                      || (in_channel_reg[3:0] == s1_status_reg[3:0]);
        zone_ok     = !($signed({1'b0, s1_first_reg}) < $signed(zone_low_reg))
                      && !((zone_high_reg != mczr_pkg::NO_BOUND)
                           && ($signed({1'b0, s1_first_reg}) > $signed(zone_high_reg)));
        note_sum    = $signed({3'b000, s1_first_reg})
                      + $signed({{2{transpose_reg[7]}}, transpose_reg});
        mapped      = rd_valid_reg ? rd_data_reg : {1'b0, s1_first_reg};
        route_pass  = chan_ok;
        route_first = s1_first_reg;
        route_status = s1_status_reg;
        case (hi) inside
            mczr_pkg::HI_NOTE_OFF, mczr_pkg::HI_NOTE_ON, mczr_pkg::HI_POLY_PRESS:
            begin
                route_pass  = chan_ok && zone_ok && (note_sum[9:7] == 3'b000);
                route_first = note_sum[6:0];
                if (rechan)
                begin
                    route_status = {hi, out_channel_reg[3:0]};
                end
            end
            mczr_pkg::HI_CONTROL:
            begin
                route_pass  = chan_ok && (mapped != mczr_pkg::MAP_BLOCKED);
                route_first = mapped[6:0];
                if (rechan)
                begin
                    route_status = {hi, out_channel_reg[3:0]};
                end
            end
            mczr_pkg::HI_PROGRAM, mczr_pkg::HI_CHAN_PRESS, mczr_pkg::HI_PITCH_BEND:
            begin
                if (rechan)
                begin
                    route_status = {hi, out_channel_reg[3:0]};
                end
            end
            default:
            begin
                route_pass = chan_ok;
            end
        endcase

        start_ch = rechan ? out_channel_reg[3:0] : 4'h0;

        case (s1_cmd_reg)
            mczr_pkg::CMD_ROUTE:
            begin
                en      = {2'b00, route_pass};
                cand[0] = '{route_status, route_first, s1_second_reg};
            end
            mczr_pkg::CMD_START:
            begin
                en      = {!program_reg[7], !bank_lsb_reg[7], !bank_msb_reg[7]};
                cand[0] = '{{mczr_pkg::HI_CONTROL, start_ch}, mczr_pkg::CC_BANK_MSB,
                            bank_msb_reg[6:0]};
            end
            default:
            begin
                en      = 3'b000;
                cand[0] = '{route_status, route_first, s1_second_reg};
            end
        endcase
        cand[1] = '{{mczr_pkg::HI_CONTROL, start_ch}, mczr_pkg::CC_BANK_LSB,
                    bank_lsb_reg[6:0]};
        cand[2] = '{{mczr_pkg::HI_PROGRAM, start_ch}, program_reg[6:0], 7'd0};

        pending  = s1_valid_reg ? (en & ~sent_reg) : 3'b000;
        sel_bit  = pending & (~pending + 3'd1);
        sel_last = ((pending & ~sel_bit) == 3'b000);
        case (sel_bit)
            3'b010:  sel_msg = cand[1];
            3'b100:  sel_msg = cand[2];
            default: sel_msg = cand[0];
        endcase

        out_load_ok = !out_valid_reg || out_ready;
        s1_fire     = (pending != 3'b000) && out_load_ok;
        s1_free     = !s1_valid_reg || (pending == 3'b000) || (s1_fire && sel_last);
        sent_next   = s1_fire ? (sent_reg | sel_bit) : sent_reg;
    end

    assign in_ready = s1_free;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sent_reg     <= 3'b000;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
            sent_reg     <= 3'b000;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= 1'b0;
            sent_reg     <= 3'b000;
        end
        else
        begin
            sent_reg <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg    <= cmd;
            s1_status_reg <= status_byte;
            s1_first_reg  <= first_data;
            s1_second_reg <= second_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            out_valid_reg <= s1_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_msg_reg  <= sel_msg;
            out_last_reg <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_msg_reg.status;
    assign out_first   = out_msg_reg.first;
    assign out_second  = out_msg_reg.second;
    assign last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    a_map_write_marks_entry : assert property (@(posedge clk) disable iff (!rst_n)
        map_wr |=> map_valid_reg[$past(map_entry[mczr_pkg::MAP_AW-1:0])])
        else $error("Map write did not mark its entry as written.");

    a_one_result_selected : assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> $onehot(sel_bit))
        else $error("Input stage selected other than one pending result.");

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (pending != 3'b000) && out_valid_reg && !out_ready |-> !in_ready)
        else $error("Input accepted while a pending result was stalled.");

    a_sent_within_enabled : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((sent_reg & ~en) == 3'b000))
        else $error("Result marked as sent that the item never enabled.");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI channel router testbench
// Sends routed messages, controller map writes and start requests into the
// router and checks every output message, in order, against the table or a
// predictor kept inside the bench. A short table of directed transactions
// comes first, then randomised phases, each under a fresh register setting
// and with random input gaps and output stalls, each turned off in one phase.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] first;
        logic [6:0] second;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [2:0]       reg_idx;
        logic [7:0]       reg_val;
        logic [1:0]       cmd;
        logic [7:0]       status;
        logic [6:0]       d1;
        logic [6:0]       d2;
        logic [6:0]       entry;
        logic [6:0]       target;
        logic             blk;
        logic [1:0]       n_typed;
        result_t [2:0]    typed;
    } row_t;

    localparam result_t NO_MSG = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = '0;
    logic [7:0] status_byte = '0;
    logic [6:0] first_data = '0;
    logic [6:0] second_data = '0;
    logic [6:0] map_entry = '0;
    logic [6:0] map_target = '0;
    logic       map_block = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_status;
    logic [6:0] out_first;
    logic [6:0] out_second;
    logic       last_of_run;

    logic signed [4:0] in_ch;
    logic signed [4:0] out_ch;
    logic signed [7:0] zone_lo;
    logic signed [7:0] zone_hi;
    logic signed [7:0] xpose;
    logic signed [7:0] bank_hi;
    logic signed [7:0] bank_lo;
    logic signed [7:0] prog_no;
    logic [7:0]        cc_map [0:127];

    result_t pending_msgs[$];
    bit      gaps_on = 1'b1;
    bit      stalls_on = 1'b1;
    int      hold_cycles = 0;
    int      items_sent = 0;
    int      map_writes = 0;
    int      starts = 0;
    int      checked = 0;
    int      mismatches = 0;
    int      settings_seen = 1;

    midi_channel_zone_cc_router DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .status_byte (status_byte),
        .first_data  (first_data),
        .second_data (second_data),
        .map_entry   (map_entry),
        .map_target  (map_target),
        .map_block   (map_block),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_status  (out_status),
        .out_first   (out_first),
        .out_second  (out_second),
        .last_of_run (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t midi_msg(input logic [7:0] st, input logic [6:0] a,
                                         input logic [6:0] b, input logic l);
        return result_t'({st, a, b, l});
    endfunction

    function automatic row_t txn_row(input logic [1:0] c, input logic [7:0] st,
                                     input logic [6:0] a, input logic [6:0] b,
                                     input logic [6:0] e, input logic [6:0] t,
                                     input logic blk);
        row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = c;
        r.status = st;
        r.d1 = a;
        r.d2 = b;
        r.entry = e;
        r.target = t;
        r.blk = blk;
        return r;
    endfunction

    function automatic row_t with_results(input row_t r, input logic [1:0] n,
                                          input result_t a, input result_t b,
                                          input result_t c);
        row_t w;
        w = r;
        w.kind = ROW_TYPED;
        w.n_typed = n;
        w.typed = {c, b, a};
        return w;
    endfunction

    function automatic row_t cfg_row(input logic [2:0] idx, input logic [7:0] val);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_setting(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 8'(lo);
        if (r < 4)
            return 8'(hi);
        if (r == 4)
            return 8'hFF;
        if (r == 5)
            return 8'($urandom);
        return 8'($urandom_range(0, hi - lo) + lo);
    endfunction

    function automatic row_t random_item();
        row_t r;
        int   pick;
        int   lo;
        int   hi;
        r = '0;
        r.kind = ROW_ITEM;
        r.status = 8'($urandom);
        r.d1 = 7'($urandom);
        r.d2 = 7'($urandom);
        r.entry = 7'($urandom);
        r.target = 7'($urandom);
        r.blk = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 1)
            r.entry[6:4] = 3'd0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            r.cmd = mczr_pkg::CMD_MAP_WRITE;
        else if (pick < 17)
            r.cmd = mczr_pkg::CMD_START;
        else if (pick < 19)
            r.cmd = CMD_UNUSED;
        else
        begin
            r.cmd = mczr_pkg::CMD_ROUTE;
            if (pick >= 30)
                r.status[7:4] = 4'($urandom_range(8, 14));
            if (in_ch >= 0 && $urandom_range(0, 4) != 0)
                r.status[3:0] = in_ch[3:0];
            if ($urandom_range(0, 1) == 1)
                r.d1[6:4] = 3'd0;
            if (r.status[7:4] >= mczr_pkg::HI_NOTE_OFF
                && r.status[7:4] <= mczr_pkg::HI_POLY_PRESS
                && $urandom_range(0, 9) < 7)
            begin
                lo = (zone_lo < 0) ? 0 : int'(zone_lo);
                hi = (zone_hi < 0) ? 127 : int'(zone_hi);
                if (lo <= hi)
                    r.d1 = 7'($urandom_range(lo, hi));
            end
        end
        return r;
    endfunction

    task automatic route_model(input row_t r, output result_t [2:0] res, output int n);
        logic [3:0] hi;
        logic [3:0] ch;
        logic [7:0] st;
        logic [6:0] d1;
        logic [7:0] mapped;
        int         note;
        res = '0;
        n = 0;
        hi = r.status[7:4];
        st = r.status;
        d1 = r.d1;
        ch = (out_ch >= 0) ? out_ch[3:0] : 4'd0;
        case (r.cmd)
            mczr_pkg::CMD_MAP_WRITE:
                cc_map[r.entry] = r.blk ? mczr_pkg::MAP_BLOCKED : {1'b0, r.target};
            mczr_pkg::CMD_START:
            begin
                if (bank_hi >= 0)
                begin
                    res[2'(n)] = midi_msg({mczr_pkg::HI_CONTROL, ch}, mczr_pkg::CC_BANK_MSB,
                                          bank_hi[6:0], 1'b0);
                    n++;
                end
                if (bank_lo >= 0)
                begin
                    res[2'(n)] = midi_msg({mczr_pkg::HI_CONTROL, ch}, mczr_pkg::CC_BANK_LSB,
                                          bank_lo[6:0], 1'b0);
                    n++;
                end
                if (prog_no >= 0)
                begin
                    res[2'(n)] = midi_msg({mczr_pkg::HI_PROGRAM, ch}, prog_no[6:0], 7'd0,
                                          1'b0);
                    n++;
                end
            end
            mczr_pkg::CMD_ROUTE:
            begin
                if (!(st < 8'hF0 && in_ch >= 0 && in_ch[3:0] != st[3:0]))
                begin
                    if (hi == mczr_pkg::HI_NOTE_OFF || hi == mczr_pkg::HI_NOTE_ON
                        || hi == mczr_pkg::HI_POLY_PRESS)
                    begin
                        note = int'(r.d1);
                        if (note >= int'(zone_lo)
                            && (zone_hi == -1 || note <= int'(zone_hi)))
                        begin
                            note += int'(xpose);
                            if (note >= 0 && note <= 127)
                            begin
                                if (out_ch >= 0)
                                    st = {hi, out_ch[3:0]};
                                res[0] = midi_msg(st, note[6:0], r.d2, 1'b0);
                                n = 1;
                            end
                        end
                    end
                    else if (hi >= mczr_pkg::HI_CONTROL && hi <= mczr_pkg::HI_PITCH_BEND)
                    begin
                        mapped = (hi == mczr_pkg::HI_CONTROL) ? cc_map[d1] : {1'b0, d1};
                        if (mapped != mczr_pkg::MAP_BLOCKED)
                        begin
                            if (out_ch >= 0)
                                st = {hi, out_ch[3:0]};
                            res[0] = midi_msg(st, mapped[6:0], r.d2, 1'b0);
                            n = 1;
                        end
                    end
                    else
                    begin
                        res[0] = midi_msg(st, d1, r.d2, 1'b0);
                        n = 1;
                    end
                end
            end
            default:
                ;
        endcase
        if (n > 0)
            res[2'(n - 1)].last = 1'b1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            mczr_pkg::REG_IN_CHANNEL:  in_ch = val[4:0];
            mczr_pkg::REG_OUT_CHANNEL: out_ch = val[4:0];
            mczr_pkg::REG_ZONE_LOW:    zone_lo = val;
            mczr_pkg::REG_ZONE_HIGH:   zone_hi = val;
            mczr_pkg::REG_TRANSPOSE:   xpose = val;
            mczr_pkg::REG_BANK_MSB:    bank_hi = val;
            mczr_pkg::REG_BANK_LSB:    bank_lo = val;
            mczr_pkg::REG_PROGRAM:     prog_no = val;
            default:                   ;
        endcase
    endtask

    task automatic wait_drain();
        while (pending_msgs.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer(input row_t r);
        int            gap;
        bit            taken;
        int            n;
        result_t [2:0] res;
        gap = gaps_on ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= r.cmd;
        status_byte <= r.status;
        first_data <= r.d1;
        second_data <= r.d2;
        map_entry <= r.entry;
        map_target <= r.target;
        map_block <= r.blk;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        route_model(r, res, n);
        if (r.kind == ROW_TYPED)
        begin
            res = r.typed;
            n = r.n_typed;
        end
        for (int i = 0; i < n; i++)
            pending_msgs.push_back(res[2'(i)]);
        items_sent++;
        if (r.cmd == mczr_pkg::CMD_MAP_WRITE)
            map_writes++;
        if (r.cmd == mczr_pkg::CMD_START)
            starts++;
    endtask

    initial
    begin : output_side
        int      stall;
        result_t got;
        result_t want;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else if (stall == 0 && stalls_on)
                stall = gap_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
                out_ready <= 1'b1;
            @(negedge clk);
            if (out_valid && out_ready)
            begin
                got = midi_msg(out_status, out_first, out_second, last_of_run);
                if (pending_msgs.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"Unexpected output message: ",
                                  "status %h first %h second %h last %b"},
                                 got.status, got.first, got.second, got.last);
                    mismatches++;
                end
                else
                begin
                    want = pending_msgs.pop_front();
                    checked++;
                    if (got.status !== want.status || got.first !== want.first
                        || got.second !== want.second || got.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"Mismatch: expected %h %h %h last %b, ",
                                      "got %h %h %h last %b"},
                                     want.status, want.first, want.second, want.last,
                                     got.status, got.first, got.second, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("midi_channel_zone_cc_router regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        row_t       script[$];
        bit         settled;
        logic [7:0] zl;
        logic [7:0] zh;
        logic [7:0] t;
        int         p;
        int         k;

        in_ch = '1;
        out_ch = '1;
        zone_lo = '1;
        zone_hi = '1;
        xpose = '0;
        bank_hi = '1;
        bank_lo = '1;
        prog_no = '1;
        for (k = 0; k < 128; k++)
            cc_map[7'(k)] = 8'(k);

        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h0}, 7'd60, 7'd100,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_NOTE_ON, 4'h0}, 7'd60, 7'd100, 1'b1), NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_SYSTEM, 4'h8}, 7'd127, 7'd127,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_SYSTEM, 4'h8}, 7'd127, 7'd127, 1'b1), NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, 8'h05, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg(8'h05, 7'd0, 7'd0, 1'b1), NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_START, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0), 2'd0,
            NO_MSG, NO_MSG, NO_MSG));
        script.push_back(txn_row(mczr_pkg::CMD_MAP_WRITE, 8'h00, 7'd0, 7'd0,
                                 7'd7, 7'd10, 1'b0));
        script.push_back(txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_CONTROL, 4'h3},
                                 7'd7, 7'd64, 7'd0, 7'd0, 1'b0));
        script.push_back(txn_row(mczr_pkg::CMD_MAP_WRITE, 8'hFF, 7'd127, 7'd127,
                                 7'd11, 7'd127, 1'b1));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_CONTROL, 4'hF}, 7'd11, 7'd1,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(CMD_UNUSED, {mczr_pkg::HI_NOTE_ON, 4'h0}, 7'd60, 7'd100,
                    7'd5, 7'd5, 1'b1), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_POLY_PRESS, 4'h5},
                                 7'd0, 7'd127, 7'd0, 7'd0, 1'b0));
        script.push_back(txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_PITCH_BEND, 4'hF},
                                 7'd127, 7'd127, 7'd0, 7'd0, 1'b0));
        script.push_back(txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_PROGRAM, 4'h2},
                                 7'd127, 7'd0, 7'd0, 7'd0, 1'b0));
        script.push_back(txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_CHAN_PRESS, 4'h0},
                                 7'd64, 7'd0, 7'd0, 7'd0, 1'b0));

        script.push_back(cfg_row(mczr_pkg::REG_IN_CHANNEL, 8'h03));
        script.push_back(cfg_row(mczr_pkg::REG_ZONE_LOW, 8'd10));
        script.push_back(cfg_row(mczr_pkg::REG_ZONE_HIGH, 8'd20));
        script.push_back(cfg_row(mczr_pkg::REG_TRANSPOSE, 8'hF6));
        script.push_back(cfg_row(mczr_pkg::REG_BANK_MSB, 8'd0));
        script.push_back(cfg_row(mczr_pkg::REG_BANK_LSB, 8'd127));
        script.push_back(cfg_row(mczr_pkg::REG_PROGRAM, 8'd5));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h3}, 7'd10, 7'd1,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_NOTE_ON, 4'h3}, 7'd0, 7'd1, 1'b1), NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h3}, 7'd9, 7'd1,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h4}, 7'd15, 7'd1,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_OFF, 4'h3}, 7'd21, 7'd0,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_CONTROL, 4'h3}, 7'd11, 7'd5,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_START, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0), 2'd3,
            midi_msg({mczr_pkg::HI_CONTROL, 4'h0}, mczr_pkg::CC_BANK_MSB, 7'd0, 1'b0),
            midi_msg({mczr_pkg::HI_CONTROL, 4'h0}, mczr_pkg::CC_BANK_LSB, 7'd127, 1'b0),
            midi_msg({mczr_pkg::HI_PROGRAM, 4'h0}, 7'd5, 7'd0, 1'b1)));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_SYSTEM, 4'h0}, 7'd0, 7'd0,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_SYSTEM, 4'h0}, 7'd0, 7'd0, 1'b1), NO_MSG, NO_MSG));

        script.push_back(cfg_row(mczr_pkg::REG_OUT_CHANNEL, 8'h0F));
        script.push_back(cfg_row(mczr_pkg::REG_TRANSPOSE, 8'h7F));
        script.push_back(cfg_row(mczr_pkg::REG_ZONE_LOW, mczr_pkg::NO_BOUND));
        script.push_back(cfg_row(mczr_pkg::REG_ZONE_HIGH, mczr_pkg::NO_BOUND));
        script.push_back(cfg_row(mczr_pkg::REG_IN_CHANNEL, 8'h1F));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h0}, 7'd0, 7'd64,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_NOTE_ON, 4'hF}, 7'd127, 7'd64, 1'b1), NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_NOTE_ON, 4'h0}, 7'd1, 7'd64,
                    7'd0, 7'd0, 1'b0), 2'd0, NO_MSG, NO_MSG, NO_MSG));
        script.push_back(with_results(
            txn_row(mczr_pkg::CMD_ROUTE, {mczr_pkg::HI_PROGRAM, 4'h0}, 7'd3, 7'd0,
                    7'd0, 7'd0, 1'b0), 2'd1,
            midi_msg({mczr_pkg::HI_PROGRAM, 4'hF}, 7'd3, 7'd0, 1'b1), NO_MSG, NO_MSG));
        script.push_back(txn_row(mczr_pkg::CMD_START, 8'h00, 7'd0, 7'd0,
                                 7'd0, 7'd0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settled = 1'b1;

        for (k = 0; k < script.size(); k++)
        begin
            if (script[k].kind == ROW_CFG)
            begin
                if (!settled)
                begin
                    wait_idle();
                    settings_seen++;
                    settled = 1'b1;
                end
                write_reg(script[k].reg_idx, script[k].reg_val);
            end
            else
            begin
                offer(script[k]);
                settled = 1'b0;
            end
        end

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            settings_seen++;
            write_reg(mczr_pkg::REG_IN_CHANNEL, (p == 0) ? 8'h00 : pick_setting(-1, 15));
            write_reg(mczr_pkg::REG_OUT_CHANNEL, (p == 0) ? 8'h0F : pick_setting(-1, 15));
            zl = (p == 0) ? 8'h00 : pick_setting(-1, 127);
            zh = (p == 0) ? 8'h7F : pick_setting(-1, 127);
            if ($signed(zl) > $signed(zh) && $signed(zh) >= 0 && $urandom_range(0, 3) != 0)
            begin
                t = zl;
                zl = zh;
                zh = t;
            end
            write_reg(mczr_pkg::REG_ZONE_LOW, zl);
            write_reg(mczr_pkg::REG_ZONE_HIGH, zh);
            t = pick_setting(-127, 127);
            if ($urandom_range(0, 1) == 1)
                t = 8'($urandom_range(0, 24) - 12);
            write_reg(mczr_pkg::REG_TRANSPOSE, (p == 0) ? 8'h81 : t);
            write_reg(mczr_pkg::REG_BANK_MSB, (p == 0) ? 8'h7F : pick_setting(-1, 127));
            write_reg(mczr_pkg::REG_BANK_LSB, (p == 0) ? 8'h00 : pick_setting(-1, 127));
            write_reg(mczr_pkg::REG_PROGRAM, (p == 0) ? 8'h7F : pick_setting(-1, 127));
            gaps_on = (p != 3);
            stalls_on = (p != 5);
            if (p == 2)
                hold_cycles = 80;
            for (k = 0; k < 38; k++)
            begin
                if (p == 4 && k == 19)
                begin
                    in_valid <= 1'b0;
                    wait_drain();
                    @(posedge clk);
                end
                offer(random_item());
            end
        end

        in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("Sent %0d transactions (%0d controller map writes, %0d start requests)",
                 items_sent, map_writes, starts);
        $display("under %0d register settings; checked %0d output messages in order, %0d mismatches.",
                 settings_seen, checked, mismatches);
        if (mismatches == 0)
            $display("midi_channel_zone_cc_router regression: pass");
        else
            $display("midi_channel_zone_cc_router regression: fail");
        $finish;
    end

endmodule
